>>> hdl/bssd_pkg.sv
// Shared types, constants and the digit encoder for the BCD seven-segment scan driver.
// No dependencies; imported by bcd_seven_segment_scan_driver_top.
package bssd_pkg;

  localparam int ValueW = 10;
  localparam int SegW   = 7;
  localparam int EnW    = 3;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [SegW-1:0]   seg_t;
  typedef logic [EnW-1:0]    en_t;
  typedef logic [3:0]        digit_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam value_t VALUE_MAX = value_t'(999);

  // Scan position: one-hot codes double as the digit enable.
  typedef enum logic [EnW-1:0] {
    SCAN_HUND  = 3'b001,
    SCAN_TENS  = 3'b010,
    SCAN_UNITS = 3'b100
  } scan_t;

  // Common cathode, bit 0 = segment a.
  function automatic seg_t seg_encode(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/bcd_seven_segment_scan_driver_top.sv
// Three-digit multiplexed seven-segment driver: input register, digit split and scan logic,
// output register. Depends on bssd_pkg.
//
//   channel | signals                      | payload
//   --------+------------------------------+----------------------------------
//   in      | in_valid / in_ready          | cmd, value
//   out     | out_valid / out_ready        | segments, digit_enable
//
// One item per cycle while no tick is held. A transfer is registered in the input register,
// then handled from there: a load rewrites the three digit patterns, a tick fills the output register.
// Reset clears the patterns to blank and points the scan at the hundreds digit.
// A tick waits in the input register only while the output register is full and not taken,
// and holds off the next transfer meanwhile; a load never waits in the input register.
module bcd_seven_segment_scan_driver_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  bssd_pkg::value_t value,
  output logic             out_valid,
  input  logic             out_ready,
  output bssd_pkg::seg_t   segments,
  output bssd_pkg::en_t    digit_enable
);
  import bssd_pkg::*;

  // input register
  logic   s1_valid;
  logic   s1_cmd;
  value_t s1_value;

  // digit store and scan
  seg_t  pat_hund, pat_tens, pat_units;
  scan_t scan, scan_next;
  seg_t  tick_seg;

  logic s1_fire;
  logic in_fire;

  assign s1_fire  = s1_valid && ((s1_cmd == CMD_LOAD) || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd   <= cmd;
      s1_value <= value;
    end
  end

  // Digit split by reciprocal multiply: v/100 = (v*41)>>12 for v < 1000,
  // r/10 = (r*205)>>11 for r < 100.
  value_t       v_sat;
  logic [15:0]  hund_prod;
  digit_t       hund;
  logic [10:0]  hund_x100;
  logic [10:0]  rem_full;
  logic [6:0]   rem;
  logic [14:0]  tens_prod;
  digit_t       tens;
  logic [6:0]   tens_x10;
  logic [6:0]   units_full;
  digit_t       units;

  always_comb begin
    v_sat      = (s1_value > VALUE_MAX) ? VALUE_MAX : s1_value;
    hund_prod  = {6'd0, v_sat} * 16'd41;
    hund       = hund_prod[15:12];
    hund_x100  = {7'd0, hund} * 11'd100;
    rem_full   = {1'b0, v_sat} - hund_x100;
    rem        = rem_full[6:0];
    tens_prod  = {8'd0, rem} * 15'd205;
    tens       = tens_prod[14:11];
    tens_x10   = {3'd0, tens} * 7'd10;
    units_full = rem - tens_x10;
    units      = units_full[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_hund  <= '0;
      pat_tens  <= '0;
      pat_units <= '0;
    end else if (s1_fire && (s1_cmd == CMD_LOAD)) begin
      pat_hund  <= seg_encode(hund);
      pat_tens  <= seg_encode(tens);
      pat_units <= seg_encode(units);
    end
  end

  always_comb begin
    case (scan)
      SCAN_HUND: begin
        tick_seg  = pat_hund;
        scan_next = SCAN_TENS;
      end
      SCAN_TENS: begin
        tick_seg  = pat_tens;
        scan_next = SCAN_UNITS;
      end
      default: begin
        tick_seg  = pat_units;
        scan_next = SCAN_HUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_HUND;
    end else if (s1_fire && (s1_cmd == CMD_TICK)) begin
      scan <= scan_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (s1_cmd == CMD_TICK)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_cmd == CMD_TICK)) begin
      segments     <= tick_seg;
      digit_enable <= (scan == SCAN_HUND || scan == SCAN_TENS) ? en_t'(scan) : en_t'(SCAN_UNITS);
    end
  end

  // assertions
  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_cmd == CMD_LOAD)) |-> in_ready)
    else $error("load held in input register");

  a_scan_hund_to_tens: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_cmd == CMD_TICK) && (scan == SCAN_HUND)) |=> (scan == SCAN_TENS))
    else $error("scan did not advance from hundreds");

  a_tick_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_cmd == CMD_TICK) && out_valid && !out_ready)
      |=> (s1_valid && $stable(scan) && $stable(segments)))
    else $error("stalled tick lost or scan moved");

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(digit_enable))
    else $error("digit enable not one-hot");

endmodule

>>> bench/seg_scan_checker.sv
// Scoreboard for the BCD seven-segment scan driver: tracks loads, predicts each tick's
// pattern and digit enable, and compares the out channel. Depends on bssd_pkg.
module seg_scan_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             cmd,
  input  bssd_pkg::value_t value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  bssd_pkg::seg_t   segments,
  input  bssd_pkg::en_t    digit_enable,
  output int               errors,
  output int               pending
);
  import bssd_pkg::*;

  typedef struct packed {
    seg_t segs;
    en_t  en;
  } lit_digit_t;

  // Common cathode glyphs for 0..9, bit 0 = segment a.
  localparam seg_t GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  seg_t       digit_pat [3];
  scan_t      scan_next;
  lit_digit_t lit_q [$];

  always @(posedge clk) begin : track
    lit_digit_t want;
    int         num;
    int         idx;
    int         err_now;
    err_now = 0;
    if (rst) begin
      foreach (digit_pat[i]) digit_pat[i] = '0;
      scan_next = SCAN_HUND;
      lit_q.delete();
    end else begin
      // results leave only after their tick has passed the input and output registers, so compare before pushing
      if (out_valid && out_ready) begin
        if (lit_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual segments %h digit_enable %b",
                   $time, segments, digit_enable);
          err_now++;
        end else begin
          want = lit_q.pop_front();
          if (segments !== want.segs) begin
            $display("%0t: segments mismatch: expected %h actual %h",
                     $time, want.segs, segments);
            err_now++;
          end
          if (digit_enable !== want.en) begin
            $display("%0t: digit_enable mismatch: expected %b actual %b",
                     $time, want.en, digit_enable);
            err_now++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == CMD_LOAD) begin
          num = (value > VALUE_MAX) ? int'(VALUE_MAX) : int'(value);
          digit_pat[0] = GLYPH[num / 100];
          digit_pat[1] = GLYPH[(num / 10) % 10];
          digit_pat[2] = GLYPH[num % 10];
        end else begin
          want.en = scan_next;
          case (scan_next)
            SCAN_HUND: begin
              idx       = 0;
              scan_next = SCAN_TENS;
            end
            SCAN_TENS: begin
              idx       = 1;
              scan_next = SCAN_UNITS;
            end
            default: begin
              idx       = 2;
              scan_next = SCAN_HUND;
            end
          endcase
          want.segs = digit_pat[idx];
          lit_q.push_back(want);
        end
      end
    end
    errors  <= errors + err_now;
    pending <= lit_q.size();
  end

endmodule

>>> bench/bcd_seven_segment_scan_driver_top_tb.sv
// Testbench top for the BCD seven-segment scan driver: clock, reset, load/tick stimulus
// with random gaps and stalls, and the verdict. Depends on bssd_pkg and seg_scan_checker.
module bcd_seven_segment_scan_driver_top_tb;
  import bssd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF    = 4;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  logic   cmd       = CMD_LOAD;
  value_t value     = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  seg_t   segments;
  en_t    digit_enable;
  int     errors;
  int     pending;
  int     cycle_count = 0;
  bit     tx_burst    = 1'b0;

  always #5 clk = ~clk;

  bcd_seven_segment_scan_driver_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segments     (segments),
    .digit_enable (digit_enable)
  );

  seg_scan_checker seg_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segments     (segments),
    .digit_enable (digit_enable),
    .errors       (errors),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bcd_seven_segment_scan_driver_top_tb NOT OK");
      $finish;
    end
  end

  // Valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic put_item(input logic c, input value_t v);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_ticks(input int n);
    repeat (n) put_item(CMD_TICK, value_t'($urandom_range(0, 1023)));
  endtask

  // Sender goes quiet until every predicted digit has been shown, plus pipeline slack.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  initial begin : receiver
    int stall;
    bit rx_burst;
    rx_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic   c;
    value_t v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // blank digits before any load, scan wraps back to hundreds
    put_ticks(4);
    put_item(CMD_LOAD, value_t'(1023));   // saturates to 999
    put_ticks(2);
    put_item(CMD_LOAD, value_t'(0));
    put_ticks(3);
    put_item(CMD_LOAD, value_t'(999));
    put_ticks(1);
    put_item(CMD_LOAD, value_t'(1000));
    put_ticks(2);
    put_item(CMD_LOAD, value_t'(682));    // 10'b1010101010
    put_ticks(1);
    put_item(CMD_LOAD, value_t'(341));    // 10'b0101010101
    put_ticks(3);
    put_item(CMD_LOAD, value_t'(575));
    put_ticks(2);
    drain();

    for (int n = 0; n < 2000; n++) begin
      if (n != 0 && n % 500 == 0) drain();
      if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
      c = ($urandom_range(0, 9) < 7) ? CMD_TICK : CMD_LOAD;
      if ($urandom_range(0, 15) == 0) v = value_t'($urandom_range(1000, 1023));
      else v = value_t'($urandom_range(0, 999));
      put_item(c, v);
    end
    drain();

    if (errors == 0 && pending == 0) begin
      $display("bcd_seven_segment_scan_driver_top_tb OK");
    end else begin
      $display("bcd_seven_segment_scan_driver_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bssd_pkg.sv
hdl/bcd_seven_segment_scan_driver_top.sv
bench/seg_scan_checker.sv
bench/bcd_seven_segment_scan_driver_top_tb.sv
